// ===== rtl/core/hsl_to_rgb_convert_defines.svh =====
// Assertion macros for the HSL to RGB conversion pipeline.
// Included by every RTL file that carries concurrent assertions; needs i_clk and i_rst_n.
`ifndef HSL_TO_RGB_CONVERT_DEFINES_SVH
`define HSL_TO_RGB_CONVERT_DEFINES_SVH
`ifndef SYNTH
`define HTR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("htr assertion failed");
`define HTR_ASSERT_HOLD(lbl, cond, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> $stable(sig)) \
        else $error("htr hold assertion failed");
`else
`define HTR_ASSERT(lbl, prop)
`define HTR_ASSERT_HOLD(lbl, cond, sig)
`endif
`endif

// ===== rtl/core/htr_pkg.sv =====
// Shared widths, constants, hue sector codes and stage structs for HSL to RGB.
// No dependencies; used by every htr module and the top level.
package htr_pkg;

    localparam int HueW    = 13;
    localparam int FracW   = 9;
    localparam int ChanW   = 8;
    localparam int ChromaW = 17;
    localparam int WgtW    = 10;
    localparam int ProdW   = ChromaW + WgtW - 1;
    localparam int QuotW   = ProdW - 6;
    localparam int SumW    = ChromaW + 1;

    localparam logic [FracW-1:0]   UNIT       = 9'd256;
    localparam logic [HueW-1:0]    HUE_SECTOR = 13'd960;
    localparam logic [HueW-1:0]    HUE_PERIOD = 13'd1920;
    localparam logic [12:0]        RECIP_15   = 13'd4369;
    localparam logic [QuotW:0]     DIV_15     = 21'd15;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic [ChromaW-1:0] c;
        logic [FracW-1:0]   l;
        logic [WgtW-1:0]    w;
        t_sector            sec;
    } t_chroma;

    typedef struct packed {
        logic [QuotW-1:0]   q;
        logic [ChromaW-1:0] y;
        logic [ChromaW-1:0] c;
        logic [ChromaW-1:0] m;
        t_sector            sec;
    } t_split;

endpackage

// ===== rtl/core/hsl_to_rgb_convert.sv =====
// Channel    Direction  Handshake                      Payload
// hsl        in         i_hsl_valid / o_hsl_ready      i_hue, i_saturation, i_lightness
// rgb        out        o_rgb_valid / i_rgb_ready      o_red, o_green, o_blue
//
// Six register stages; a transaction taken on hsl shows on rgb once it has passed through all six.
// One transaction per clock when the output side keeps ready high.
// The whole pipeline advances on one enable: output register empty or being taken.
// A stall freezes every stage in place; nothing is dropped or repeated.
// Reset clears the stage valid bits only.
// Depends on htr_pkg, htr_front, htr_xdiv, htr_mix.
module hsl_to_rgb_convert (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_hsl_valid,
    output logic                         o_hsl_ready,
    input  logic [htr_pkg::HueW-1:0]     i_hue,
    input  logic [htr_pkg::FracW-1:0]    i_saturation,
    input  logic [htr_pkg::FracW-1:0]    i_lightness,
    output logic                         o_rgb_valid,
    input  logic                         i_rgb_ready,
    output logic [htr_pkg::ChanW-1:0]    o_red,
    output logic [htr_pkg::ChanW-1:0]    o_green,
    output logic [htr_pkg::ChanW-1:0]    o_blue
);

    logic             en;
    logic             v_front, v_xdiv;
    htr_pkg::t_chroma d_front;
    htr_pkg::t_split  d_xdiv;

    assign en          = !o_rgb_valid || i_rgb_ready;
    assign o_hsl_ready = en;

    htr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_hsl_valid),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (v_front),
        .o_data       (d_front)
    );

    htr_xdiv u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_front),
        .i_data  (d_front),
        .o_valid (v_xdiv),
        .o_data  (d_xdiv)
    );

    htr_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_xdiv),
        .i_data  (d_xdiv),
        .o_valid (o_rgb_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

// ===== rtl/core/htr_front.sv =====
// Stages 1 and 2: saturate inputs, find hue sector and weight, multiply out chroma.
// Depends on htr_pkg and hsl_to_rgb_convert_defines.svh.
`include "hsl_to_rgb_convert_defines.svh"
module htr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [htr_pkg::HueW-1:0]       i_hue,
    input  logic [htr_pkg::FracW-1:0]      i_saturation,
    input  logic [htr_pkg::FracW-1:0]      i_lightness,
    output logic                           o_valid,
    output htr_pkg::t_chroma               o_data
);

    logic [htr_pkg::FracW-1:0] n_s, n_l, n_a, l_dev;
    logic [htr_pkg::FracW:0]   two_l;
    logic [htr_pkg::HueW-1:0]  rem, base, rdist;
    logic [htr_pkg::WgtW-1:0]  n_w;
    htr_pkg::t_sector          n_sec;
    logic [8:1]                ge;

    logic                      r_v1;
    logic [htr_pkg::FracW-1:0] r_a, r_s, r_l;
    logic [htr_pkg::WgtW-1:0]  r_w;
    htr_pkg::t_sector          r_sec;
    logic                      r_v2;
    htr_pkg::t_chroma          r_out;

    always_comb begin
        n_s   = (i_saturation > htr_pkg::UNIT) ? htr_pkg::UNIT : i_saturation;
        n_l   = (i_lightness > htr_pkg::UNIT) ? htr_pkg::UNIT : i_lightness;
        two_l = {n_l, 1'b0};
        if (two_l >= {1'b0, htr_pkg::UNIT}) begin
            l_dev = htr_pkg::FracW'(two_l - {1'b0, htr_pkg::UNIT});
        end else begin
            l_dev = htr_pkg::FracW'({1'b0, htr_pkg::UNIT} - two_l);
        end
        n_a = htr_pkg::UNIT - l_dev;

        for (int k = 1; k <= 8; k++) begin
            ge[k] = ({3'b0, i_hue} >= 16'(k) * 16'(htr_pkg::HUE_SECTOR));
        end
        if (ge[5]) begin
            n_sec = htr_pkg::SEC_MR;
        end else if (ge[4]) begin
            n_sec = htr_pkg::SEC_BM;
        end else if (ge[3]) begin
            n_sec = htr_pkg::SEC_CB;
        end else if (ge[2]) begin
            n_sec = htr_pkg::SEC_GC;
        end else if (ge[1]) begin
            n_sec = htr_pkg::SEC_YG;
        end else begin
            n_sec = htr_pkg::SEC_RY;
        end

        if (ge[8]) begin
            base = htr_pkg::HueW'(4 * htr_pkg::HUE_PERIOD);
        end else if (ge[6]) begin
            base = htr_pkg::HueW'(3 * htr_pkg::HUE_PERIOD);
        end else if (ge[4]) begin
            base = htr_pkg::HueW'(2 * htr_pkg::HUE_PERIOD);
        end else if (ge[2]) begin
            base = htr_pkg::HUE_PERIOD;
        end else begin
            base = '0;
        end
        rem = i_hue - base;
        if (rem >= htr_pkg::HUE_SECTOR) begin
            rdist = rem - htr_pkg::HUE_SECTOR;
        end else begin
            rdist = htr_pkg::HUE_SECTOR - rem;
        end
        n_w = htr_pkg::WgtW'(htr_pkg::HUE_SECTOR - rdist);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a       <= n_a;
            r_s       <= n_s;
            r_l       <= n_l;
            r_w       <= n_w;
            r_sec     <= n_sec;
            r_out.c   <= htr_pkg::ChromaW'(r_a * r_s);
            r_out.l   <= r_l;
            r_out.w   <= r_w;
            r_out.sec <= r_sec;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_out;

    `HTR_ASSERT(a_weight_range, r_v1 |-> (r_w <= htr_pkg::WgtW'(htr_pkg::HUE_SECTOR)))
    `HTR_ASSERT(a_chroma_range, r_v2 |-> (r_out.c <= htr_pkg::ChromaW'(65536)))

endmodule

// ===== rtl/core/htr_xdiv.sv =====
// Stages 3 and 4: weight chroma, form the offset m, estimate the divide by 960.
// Depends on htr_pkg and hsl_to_rgb_convert_defines.svh.
`include "hsl_to_rgb_convert_defines.svh"
module htr_xdiv (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  htr_pkg::t_chroma i_data,
    output logic             o_valid,
    output htr_pkg::t_split  o_data
);

    logic [htr_pkg::ProdW-1:0]   prod;
    logic [htr_pkg::ChromaW-1:0] n_m, lq;
    logic [htr_pkg::QuotW+12:0]  est;

    logic                        r_v3;
    logic [htr_pkg::QuotW-1:0]   r_q;
    logic [htr_pkg::ChromaW-1:0] r_c, r_m;
    htr_pkg::t_sector            r_sec;
    logic                        r_v4;
    htr_pkg::t_split             r_out;

    always_comb begin
        prod = htr_pkg::ProdW'(i_data.c * i_data.w);
        lq   = {i_data.l, 8'b0};
        n_m  = (lq >= {1'b0, i_data.c[htr_pkg::ChromaW-1:1]}) ?
               lq - {1'b0, i_data.c[htr_pkg::ChromaW-1:1]} : '0;
        est  = r_q * htr_pkg::RECIP_15;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q       <= prod[htr_pkg::ProdW-1:6];
            r_c       <= i_data.c;
            r_m       <= n_m;
            r_sec     <= i_data.sec;
            r_out.q   <= r_q;
            r_out.y   <= est[htr_pkg::QuotW+12:16];
            r_out.c   <= r_c;
            r_out.m   <= r_m;
            r_out.sec <= r_sec;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = r_out;

    `HTR_ASSERT(a_offset_no_floor, i_valid |-> (lq >= {1'b0, i_data.c[htr_pkg::ChromaW-1:1]}))

endmodule

// ===== rtl/core/htr_mix.sv =====
// Stages 5 and 6: finish the divide, permute by sector, scale and clamp channels.
// Depends on htr_pkg and hsl_to_rgb_convert_defines.svh.
`include "hsl_to_rgb_convert_defines.svh"
module htr_mix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  htr_pkg::t_split              i_data,
    output logic                         o_valid,
    output logic [htr_pkg::ChanW-1:0]    o_red,
    output logic [htr_pkg::ChanW-1:0]    o_green,
    output logic [htr_pkg::ChanW-1:0]    o_blue
);

    logic [htr_pkg::QuotW:0]     rr;
    logic [htr_pkg::ChromaW-1:0] x, rt, gt, bt;

    logic                        r_v5;
    logic [htr_pkg::SumW-1:0]    r_tr, r_tg, r_tb;
    logic                        r_v6;
    logic [htr_pkg::ChanW-1:0]   r_red, r_green, r_blue;

    function automatic logic [htr_pkg::ChanW-1:0] to_chan(input logic [htr_pkg::SumW-1:0] t);
        logic [htr_pkg::SumW+7:0] sc;
        sc = {t, 8'b0} - {8'b0, t};
        return (sc[htr_pkg::SumW+7:16] > 'd255) ? 8'd255 : htr_pkg::ChanW'(sc[htr_pkg::SumW+7:16]);
    endfunction

    always_comb begin
        rr = {1'b0, i_data.q} - (htr_pkg::QuotW+1)'({4'b0, i_data.y} * htr_pkg::DIV_15);
        x  = (rr >= htr_pkg::DIV_15) ? i_data.y + htr_pkg::ChromaW'(1) : i_data.y;
        case (i_data.sec)
            htr_pkg::SEC_RY: begin rt = i_data.c; gt = x;        bt = '0;       end
            htr_pkg::SEC_YG: begin rt = x;        gt = i_data.c; bt = '0;       end
            htr_pkg::SEC_GC: begin rt = '0;       gt = i_data.c; bt = x;        end
            htr_pkg::SEC_CB: begin rt = '0;       gt = x;        bt = i_data.c; end
            htr_pkg::SEC_BM: begin rt = x;        gt = '0;       bt = i_data.c; end
            default:         begin rt = i_data.c; gt = '0;       bt = x;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tr    <= {1'b0, rt} + {1'b0, i_data.m};
            r_tg    <= {1'b0, gt} + {1'b0, i_data.m};
            r_tb    <= {1'b0, bt} + {1'b0, i_data.m};
            r_red   <= to_chan(r_tr);
            r_green <= to_chan(r_tg);
            r_blue  <= to_chan(r_tb);
        end
    end

    assign o_valid = r_v6;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    `HTR_ASSERT(a_x_below_chroma, i_valid |-> (x <= i_data.c))
    `HTR_ASSERT(a_div_exact, i_valid |-> (rr < (htr_pkg::QuotW+1)'(30)))
    `HTR_ASSERT_HOLD(a_stall_holds, !i_en, {r_v5, r_v6, r_red, r_green, r_blue})

endmodule

// ===== verif/tb_hsl_to_rgb_convert.sv =====
// Testbench for hsl_to_rgb_convert: directed corners, random colors and back-pressure.
// Predicts every color locally and checks it against the rgb channel in order.
// Depends on htr_pkg and the hsl_to_rgb_convert RTL.
module tb_hsl_to_rgb_convert;

    localparam int WatchdogLimit = 2000;
    localparam int HoldLength    = 250;
    localparam int MaxPrinted    = 100;

    typedef struct packed {
        logic [htr_pkg::HueW-1:0]  hue;
        logic [htr_pkg::FracW-1:0] sat;
        logic [htr_pkg::FracW-1:0] light;
        logic [htr_pkg::ChanW-1:0] red;
        logic [htr_pkg::ChanW-1:0] green;
        logic [htr_pkg::ChanW-1:0] blue;
    } t_color;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_hsl_valid  = 1'b0;
    logic [htr_pkg::HueW-1:0]   i_hue        = '0;
    logic [htr_pkg::FracW-1:0]  i_saturation = '0;
    logic [htr_pkg::FracW-1:0]  i_lightness  = '0;
    logic                       i_rgb_ready  = 1'b0;
    logic                       o_hsl_ready;
    logic                       o_rgb_valid;
    logic [htr_pkg::ChanW-1:0]  o_red;
    logic [htr_pkg::ChanW-1:0]  o_green;
    logic [htr_pkg::ChanW-1:0]  o_blue;

    t_color rgb_pending[$];
    int     error_count   = 0;
    int     idle_cycles   = 0;
    int     burst_left    = 0;
    int     hold_requests = 0;
    int     holds_served  = 0;
    int     hold_left     = 0;
    int     ready_mode    = 0;
    int     mode_left     = 0;
    int     rx_cycle      = 0;

    hsl_to_rgb_convert dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hsl_valid  (i_hsl_valid),
        .o_hsl_ready  (o_hsl_ready),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_rgb_valid  (o_rgb_valid),
        .i_rgb_ready  (i_rgb_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [htr_pkg::ChanW-1:0] to_intensity(input longint unsigned q16);
        longint unsigned v;
        v = (q16 * 255) >> 16;
        return (v > 255) ? 8'd255 : v[htr_pkg::ChanW-1:0];
    endfunction

    function automatic t_color rgb_of_hsl(input logic [htr_pkg::HueW-1:0] hue,
                                          input logic [htr_pkg::FracW-1:0] sat,
                                          input logic [htr_pkg::FracW-1:0] light);
        longint unsigned unit, per, sec_w;
        longint unsigned s, l, two_l, l_dev, c, rem, rdist, x, half, m, sector;
        longint unsigned rt, gt, bt;
        t_color res;
        unit   = 64'(htr_pkg::UNIT);
        per    = 64'(htr_pkg::HUE_PERIOD);
        sec_w  = 64'(htr_pkg::HUE_SECTOR);
        s      = (64'(sat) > unit) ? unit : 64'(sat);
        l      = (64'(light) > unit) ? unit : 64'(light);
        two_l  = 2 * l;
        l_dev  = (two_l >= unit) ? two_l - unit : unit - two_l;
        c      = (unit - l_dev) * s;
        rem    = 64'(hue) % per;
        rdist  = (rem >= sec_w) ? rem - sec_w : sec_w - rem;
        x      = (c * (sec_w - rdist)) / sec_w;
        half   = c >> 1;
        m      = (unit * l >= half) ? unit * l - half : 0;
        sector = 64'(hue) / sec_w;
        case (sector)
            64'(htr_pkg::SEC_RY): begin rt = c; gt = x; bt = 0; end
            64'(htr_pkg::SEC_YG): begin rt = x; gt = c; bt = 0; end
            64'(htr_pkg::SEC_GC): begin rt = 0; gt = c; bt = x; end
            64'(htr_pkg::SEC_CB): begin rt = 0; gt = x; bt = c; end
            64'(htr_pkg::SEC_BM): begin rt = x; gt = 0; bt = c; end
            default:              begin rt = c; gt = 0; bt = x; end
        endcase
        res.hue   = hue;
        res.sat   = sat;
        res.light = light;
        res.red   = to_intensity(rt + m);
        res.green = to_intensity(gt + m);
        res.blue  = to_intensity(bt + m);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MaxPrinted) begin
            $display("MISMATCH @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic send_hsl(input logic [htr_pkg::HueW-1:0] hue,
                            input logic [htr_pkg::FracW-1:0] sat,
                            input logic [htr_pkg::FracW-1:0] light);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_hsl_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        i_hsl_valid  <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_lightness  <= light;
        @(posedge i_clk);
        while (!o_hsl_ready) @(posedge i_clk);
        rgb_pending.push_back(rgb_of_hsl(hue, sat, light));
        burst_left--;
    endtask

    function automatic logic [htr_pkg::FracW-1:0] rand_frac();
        return ($urandom_range(0, 7) == 0) ? htr_pkg::FracW'($urandom_range(0, 511))
                                           : htr_pkg::FracW'($urandom_range(0, 256));
    endfunction

    function automatic logic [htr_pkg::HueW-1:0] rand_hue(input int unsigned hi);
        return htr_pkg::HueW'($urandom_range(0, hi));
    endfunction

    function automatic logic [htr_pkg::FracW-1:0] rand_raw(input int unsigned hi);
        return htr_pkg::FracW'($urandom_range(0, hi));
    endfunction

    task automatic test_corners();
        send_hsl(13'd0,    9'd256, 9'd128);
        send_hsl(13'd959,  9'd256, 9'd128);
        send_hsl(13'd960,  9'd256, 9'd128);
        send_hsl(13'd1919, 9'd256, 9'd128);
        send_hsl(13'd1920, 9'd256, 9'd128);
        send_hsl(13'd2879, 9'd256, 9'd128);
        send_hsl(13'd2880, 9'd256, 9'd128);
        send_hsl(13'd3839, 9'd256, 9'd128);
        send_hsl(13'd3840, 9'd256, 9'd128);
        send_hsl(13'd4799, 9'd256, 9'd128);
        send_hsl(13'd4800, 9'd256, 9'd128);
        send_hsl(13'd5759, 9'd256, 9'd128);
        send_hsl(13'd5760, 9'd256, 9'd128);
        send_hsl(13'd8191, 9'd256, 9'd128);
        send_hsl(13'd8191, 9'd511, 9'd511);
        send_hsl(13'd3000, 9'd0,   9'd100);
        send_hsl(13'd1234, 9'd256, 9'd0);
        send_hsl(13'd4321, 9'd256, 9'd256);
        send_hsl(13'd100,  9'd0,   9'd0);
        send_hsl(13'd2000, 9'd511, 9'd300);
        send_hsl(13'd700,  9'd300, 9'd511);
        send_hsl(13'd0,    9'd0,   9'd256);
        send_hsl(13'd5000, 9'd1,   9'd1);
    endtask

    task automatic test_in_range(input int count);
        repeat (count) send_hsl(rand_hue(5759), rand_raw(256), rand_raw(256));
    endtask

    task automatic test_sector_edges(input int count);
        int h;
        repeat (count) begin
            h = 960 * $urandom_range(0, 6) + $urandom_range(0, 4) - 2;
            if (h < 0) h = 0;
            send_hsl(h[htr_pkg::HueW-1:0], rand_frac(), rand_frac());
        end
    endtask

    task automatic test_out_of_range(input int count);
        repeat (count) send_hsl(rand_hue(8191), rand_raw(511), rand_raw(511));
    endtask

    task automatic test_backpressure(input int count);
        hold_requests++;
        repeat (count) send_hsl(rand_hue(5759), rand_frac(), rand_frac());
    endtask

    task automatic test_mixed(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                send_hsl(rand_hue(8191), rand_raw(511), rand_raw(511));
            end else begin
                send_hsl(rand_hue(5759), rand_frac(), rand_frac());
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_color want;
        if (i_rst_n && o_rgb_valid && i_rgb_ready) begin
            if (rgb_pending.size() == 0) begin
                report_mismatch($sformatf("unexpected rgb %0d %0d %0d", o_red, o_green, o_blue));
            end else begin
                want = rgb_pending.pop_front();
                if (o_red !== want.red)
                    report_mismatch($sformatf("red %0d want %0d (h=%0d s=%0d l=%0d)",
                        o_red, want.red, want.hue, want.sat, want.light));
                if (o_green !== want.green)
                    report_mismatch($sformatf("green %0d want %0d (h=%0d s=%0d l=%0d)",
                        o_green, want.green, want.hue, want.sat, want.light));
                if (o_blue !== want.blue)
                    report_mismatch($sformatf("blue %0d want %0d (h=%0d s=%0d l=%0d)",
                        o_blue, want.blue, want.hue, want.sat, want.light));
            end
        end
        rx_cycle++;
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left = HoldLength;
        end
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_rgb_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0:       i_rgb_ready <= 1'b1;
                1:       i_rgb_ready <= ($urandom_range(0, 3) != 0);
                default: i_rgb_ready <= ((rx_cycle % 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_hsl_valid && o_hsl_ready) || (o_rgb_valid && i_rgb_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_in_range(800);
        test_sector_edges(200);
        test_backpressure(100);
        test_out_of_range(300);
        test_backpressure(60);
        test_mixed(270);
        i_hsl_valid <= 1'b0;
        while (rgb_pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && rgb_pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/htr_pkg.sv
rtl/core/htr_front.sv
rtl/core/htr_xdiv.sv
rtl/core/htr_mix.sv
rtl/core/hsl_to_rgb_convert.sv
verif/tb_hsl_to_rgb_convert.sv
